>>> rtl/smpf_pkg.sv
// Shared types and codes for the strict priority multi-FIFO.
// No dependencies; every other file imports this package.
package smpf_pkg;

    localparam int LVL_W  = 2;   // width of the level fields
    localparam int WORD_W = 32;  // width of the data ports

    typedef enum logic {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

    // item requests into the pointer bank
    typedef struct packed {
        logic enq;
        logic deq;
    } t_ptr_req;

    // qualified grants out of the pointer bank
    typedef struct packed {
        logic enq_ok;
        logic deq_ok;
    } t_ptr_rsp;

    // entry store access
    typedef struct packed {
        logic wr;
        logic rd;
    } t_mem_cmd;

endpackage

>>> rtl/smpf_store.sv
// Entry store: one single-port synchronous RAM holding all levels' rings.
// Depends on smpf_pkg for the access command struct.
module smpf_store
    import smpf_pkg::*;
#(
    parameter int ENTRIES = 64,
    parameter int DW      = 32,
    localparam int ADDR_W = $clog2(ENTRIES)
) (
    input  logic              i_clk,
    input  t_mem_cmd          i_cmd,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DW-1:0]     i_wdata,
    output logic [DW-1:0]     o_rdata
);

    logic [DW-1:0] r_mem [ENTRIES];
    logic [DW-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_cmd.rd) begin
            r_q <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_q;

endmodule

>>> rtl/smpf_ptrs.sv
// Pointer bank: head, tail and occupancy per level, priority pick and
// entry store address generation. Depends on smpf_pkg.
module smpf_ptrs
    import smpf_pkg::*;
#(
    parameter int LEVELS  = 4,
    parameter int DEPTH   = 16,
    localparam int LIDX_W = $clog2(LEVELS),
    localparam int ADDR_W = $clog2(LEVELS * DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ptr_req          i_req,
    input  logic [LVL_W-1:0]  i_level,
    output t_ptr_rsp          o_rsp,
    output logic [LIDX_W-1:0] o_deq_level,
    output logic [ADDR_W-1:0] o_addr
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [ADDR_W-1:0] DEPTH_A = ADDR_W'(DEPTH);
    localparam logic [CNT_W-1:0]  FULL_C  = CNT_W'(DEPTH);

    logic [PTR_W-1:0] r_head [LEVELS];
    logic [PTR_W-1:0] r_tail [LEVELS];
    logic [CNT_W-1:0] r_occ  [LEVELS];
    logic [PTR_W-1:0] n_head [LEVELS];
    logic [PTR_W-1:0] n_tail [LEVELS];
    logic [CNT_W-1:0] n_occ  [LEVELS];

    logic              lvl_ok;
    logic [LIDX_W-1:0] lidx;
    logic              found;
    logic [LIDX_W-1:0] pick;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // lowest-numbered non-empty level wins
    always_comb begin
        found = 1'b0;
        pick  = '0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (r_occ[i] != '0) begin
                found = 1'b1;
                pick  = LIDX_W'(i);
            end
        end
    end

    always_comb begin
        lvl_ok        = (int'(i_level) < LEVELS);
        lidx          = LIDX_W'(i_level);
        o_rsp.enq_ok  = i_req.enq && lvl_ok && (r_occ[lidx] != FULL_C);
        o_rsp.deq_ok  = i_req.deq && found;
        o_deq_level   = pick;
        if (i_req.enq) begin
            o_addr = ADDR_W'(lidx) * DEPTH_A + ADDR_W'(r_tail[lidx]);
        end else begin
            o_addr = ADDR_W'(pick) * DEPTH_A + ADDR_W'(r_head[pick]);
        end
    end

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_occ  = r_occ;
        if (o_rsp.enq_ok) begin
            n_tail[lidx] = ring_next(r_tail[lidx]);
            n_occ[lidx]  = r_occ[lidx] + 1'b1;
        end
        if (o_rsp.deq_ok) begin
            n_head[pick] = ring_next(r_head[pick]);
            n_occ[pick]  = r_occ[pick] - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LEVELS; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_occ[i]  <= '0;
            end
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_occ  <= n_occ;
        end
    end

endmodule

>>> rtl/strict_priority_multi_fifo_top.sv
// Strict priority multi-FIFO top level: command FSM and result registers.
// Depends on smpf_pkg, smpf_ptrs and smpf_store.
//
//   channel  | handshake            | fields
//   ---------+----------------------+-------------------------------------
//   command  | i_start / o_busy     | i_cmd, i_level, i_data_in
//   result   | o_done (1 cycle)     | o_status, o_data_out, o_level_out
//
// Enqueue and any rejected item: accepted and retired without going busy, result
// strobed the cycle after; enqueues can issue every cycle while o_busy is low.
// Successful dequeue: busy in S_READ while the RAM read returns, so no new item
// is taken until that read has delivered its result.
// A write always lands before any later read, so no forwarding is needed.
// Synchronous active-low reset empties every level; no clearing pass.
// Results cannot be stalled by the receiver.
module strict_priority_multi_fifo_top
    import smpf_pkg::*;
#(
    parameter int LEVELS     = 4,
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic              i_cmd,
    input  logic [LVL_W-1:0]  i_level,
    input  logic [WORD_W-1:0] i_data_in,
    output logic              o_done,
    output logic [1:0]        o_status,
    output logic [WORD_W-1:0] o_data_out,
    output logic [LVL_W-1:0]  o_level_out
);

    localparam int ENTRIES = LEVELS * DEPTH;
    localparam int ADDR_W  = $clog2(ENTRIES);
    localparam int LIDX_W  = $clog2(LEVELS);
    localparam int SW      = (DATA_WIDTH < WORD_W) ? DATA_WIDTH : WORD_W;

    t_state            r_state, n_state;
    logic              r_done, n_done;
    t_status           r_status, n_status;
    logic [WORD_W-1:0] r_dout, n_dout;
    logic [LVL_W-1:0]  r_lout, n_lout;
    logic [LIDX_W-1:0] r_lvl, n_lvl;

    logic              accept;
    t_ptr_req          req;
    t_ptr_rsp          rsp;
    t_mem_cmd          mcmd;
    logic [LIDX_W-1:0] deq_level;
    logic [ADDR_W-1:0] addr;
    logic [SW-1:0]     rdata;

    assign o_busy = (r_state != S_IDLE);
    assign accept = i_start && !o_busy;
    assign req.enq = accept && (t_cmd'(i_cmd) == CMD_ENQ);
    assign req.deq = accept && (t_cmd'(i_cmd) == CMD_DEQ);
    assign mcmd.wr = rsp.enq_ok;
    assign mcmd.rd = rsp.deq_ok;

    smpf_ptrs #(
        .LEVELS (LEVELS),
        .DEPTH  (DEPTH)
    ) u_ptrs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .i_level     (i_level),
        .o_rsp       (rsp),
        .o_deq_level (deq_level),
        .o_addr      (addr)
    );

    smpf_store #(
        .ENTRIES (ENTRIES),
        .DW      (SW)
    ) u_store (
        .i_clk   (i_clk),
        .i_cmd   (mcmd),
        .i_addr  (addr),
        .i_wdata (SW'(i_data_in)),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (rsp.deq_ok) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_done   = 1'b0;
        n_status = ST_OK;
        n_dout   = '0;
        n_lout   = '0;
        n_lvl    = r_lvl;
        unique case (r_state)
            S_IDLE: begin
                if (rsp.deq_ok) begin
                    n_lvl = deq_level;
                end else if (accept) begin
                    n_done = 1'b1;
                    if (req.enq) begin
                        n_status = rsp.enq_ok ? ST_OK : ST_FULL;
                    end else begin
                        n_status = ST_EMPTY;
                    end
                end
            end
            S_READ: begin
                n_done   = 1'b1;
                n_status = ST_OK;
                n_dout   = WORD_W'(rdata);
                n_lout   = LVL_W'(r_lvl);
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_dout   <= n_dout;
        r_lout   <= n_lout;
        r_lvl    <= n_lvl;
    end

    assign o_done      = r_done;
    assign o_status    = r_status;
    assign o_data_out  = r_dout;
    assign o_level_out = r_lout;

endmodule

>>> rtl/smpf_chk.sv
// Port-level checker for the strict priority multi-FIFO, bound to the top.
// Depends on smpf_pkg for the status codes.
module smpf_chk
    import smpf_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_start,
    input logic              o_busy,
    input logic              i_cmd,
    input logic              o_done,
    input logic [1:0]        o_status,
    input logic [WORD_W-1:0] o_data_out,
    input logic [LVL_W-1:0]  o_level_out
);

    // an enqueue item retires in the next cycle with ok or full, payload zero
    a_enq_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_cmd == CMD_ENQ) |=>
            (o_done && !o_busy && o_status != ST_EMPTY
             && o_data_out == '0 && o_level_out == '0))
        else $error("enqueue item did not retire as expected");

    // a dequeue item either goes busy for the read or reports empty at once
    a_deq_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_cmd == CMD_DEQ) |=>
            ((o_busy && !o_done) || (o_done && o_status == ST_EMPTY)))
        else $error("dequeue item took an unexpected path");

    // the busy cycle always ends in a successful pop
    a_busy_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |=> (o_done && !o_busy && o_status == ST_OK))
        else $error("busy cycle not followed by a popped item");

    // no result without an item behind it
    a_done_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(i_start && !o_busy) || $past(o_busy)))
        else $error("result strobe without an accepted item");

    // failed items carry zero payload
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |->
            (o_data_out == '0 && o_level_out == '0 && o_status != 2'd3))
        else $error("failed item with nonzero payload");

endmodule

bind strict_priority_multi_fifo_top smpf_chk u_smpf_chk (.*);

>>> bench/tb.sv
// Self-checking bench for strict_priority_multi_fifo_top: a directed table and random
// enqueue/dequeue traffic, checked against a per-level ring model or typed rows.
// Depends on smpf_pkg and the RTL under rtl/.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import smpf_pkg::*;

    localparam int NUM_LEVELS  = 4;
    localparam int FIFO_DEPTH  = 16;
    localparam int QUIET_LIMIT = 1000;
    localparam int PHASE_ITEMS = 400;

    typedef struct packed {
        t_status            status;
        logic [WORD_W-1:0]  data;
        logic [LVL_W-1:0]   level;
    } t_result;

    typedef struct {
        t_cmd               cmd;
        logic [LVL_W-1:0]   level;
        logic [WORD_W-1:0]  data;
        int                 reps;
        bit                 typed;
        t_result            want;
    } t_row;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    t_cmd              cmd;
    logic [LVL_W-1:0]  lvl;
    logic [WORD_W-1:0] data_word;
    logic              done;
    logic [1:0]        status;
    logic [WORD_W-1:0] data_out;
    logic [LVL_W-1:0]  level_out;

    strict_priority_multi_fifo_top #(
        .LEVELS     (NUM_LEVELS),
        .DEPTH      (FIFO_DEPTH),
        .DATA_WIDTH (WORD_W)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_cmd       (cmd),
        .i_level     (lvl),
        .i_data_in   (data_word),
        .o_done      (done),
        .o_status    (status),
        .o_data_out  (data_out),
        .o_level_out (level_out)
    );

    // model state: one ring per level
    logic [WORD_W-1:0] ring_slots [NUM_LEVELS][FIFO_DEPTH];
    int                head_idx [NUM_LEVELS];
    int                tail_idx [NUM_LEVELS];
    int                fill [NUM_LEVELS];

    t_result pending_results[$];
    t_row    directed_rows[$];

    // hand-typed expectation that travels with the item being driven
    bit      drv_typed;
    t_result drv_want;

    int errors;
    int quiet_cycles;
    int n_items, n_enq_ok, n_full, n_deq_ok, n_empty, n_results;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic t_result predict_queue_result(t_cmd c, logic [LVL_W-1:0] l,
                                                     logic [WORD_W-1:0] d);
        t_result r;
        r = '{ST_OK, '0, '0};
        if (c == CMD_ENQ) begin
            if (fill[l] >= FIFO_DEPTH) begin
                r.status = ST_FULL;
                n_full++;
            end else begin
                ring_slots[l][tail_idx[l]] = d;
                tail_idx[l] = (tail_idx[l] + 1) % FIFO_DEPTH;
                fill[l]++;
                n_enq_ok++;
            end
        end else begin
            r.status = ST_EMPTY;
            for (int i = 0; i < NUM_LEVELS; i++) begin
                if (r.status == ST_EMPTY && fill[i] != 0) begin
                    r.status = ST_OK;
                    r.data   = ring_slots[i][head_idx[i]];
                    r.level  = LVL_W'(i);
                    head_idx[i] = (head_idx[i] + 1) % FIFO_DEPTH;
                    fill[i]--;
                end
            end
            if (r.status == ST_OK) n_deq_ok++;
            else n_empty++;
        end
        return r;
    endfunction

    function automatic void add_row(t_cmd c, logic [LVL_W-1:0] l, logic [WORD_W-1:0] d,
                                    int n, bit typed, t_status st,
                                    logic [WORD_W-1:0] wd, logic [LVL_W-1:0] wl);
        t_row row;
        row.cmd   = c;
        row.level = l;
        row.data  = d;
        row.reps  = n;
        row.typed = typed;
        row.want  = '{st, wd, wl};
        directed_rows.push_back(row);
    endfunction

    // called just after a falling edge; returns just after the falling edge
    // that follows acceptance
    task automatic send_item(t_cmd c, logic [LVL_W-1:0] l, logic [WORD_W-1:0] d,
                             bit typed, t_result want, int idle_pct);
        if ($urandom_range(99) < idle_pct) begin
            start     <= 1'b0;
            cmd       <= t_cmd'($urandom_range(1));
            lvl       <= LVL_W'($urandom);
            data_word <= $urandom;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        cmd       <= c;
        lvl       <= l;
        data_word <= d;
        start     <= 1'b1;
        drv_typed = typed;
        drv_want  = want;
        do @(posedge clk); while (!(start && !busy));
        @(negedge clk);
    endtask

    // result checking, prediction and the watchdog
    always @(posedge clk) begin
        t_result want;
        if (rst_n) begin
            if (done) begin
                n_results++;
                if (pending_results.size() == 0) begin
                    $error("unexpected result: status %0d data_out %h level_out %0d",
                           status, data_out, level_out);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (status != want.status) begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        errors++;
                    end
                    if (data_out != want.data) begin
                        $error("data_out: expected %h, got %h", want.data, data_out);
                        errors++;
                    end
                    if (level_out != want.level) begin
                        $error("level_out: expected %0d, got %0d", want.level, level_out);
                        errors++;
                    end
                end
            end
            if (start && !busy) begin
                want = predict_queue_result(cmd, lvl, data_word);
                if (drv_typed) want = drv_want;
                pending_results.push_back(want);
                n_items++;
            end
            if (done || (start && !busy)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no item or result for %0d cycles", QUIET_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        t_result none;
        t_cmd    c;
        int      idle_pct, burst_idle, enq_bias, burst_len, sent, pin_level;
        logic [LVL_W-1:0]  l;
        logic [WORD_W-1:0] d;

        none         = '{ST_OK, '0, '0};
        errors       = 0;
        quiet_cycles = 0;
        start        = 1'b0;
        cmd          = CMD_ENQ;
        lvl          = '0;
        data_word    = '0;
        drv_typed    = 1'b0;
        drv_want     = none;
        rst_n        = 1'b0;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            head_idx[i] = 0;
            tail_idx[i] = 0;
            fill[i]     = 0;
        end

        // empty queue, one word per level (all-zero, all-one, alternating bits), priority order
        add_row(CMD_DEQ, 0, 0, 1, 1, ST_EMPTY, 0, 0);
        add_row(CMD_ENQ, 3, '1, 1, 1, ST_OK, 0, 0);
        add_row(CMD_ENQ, 0, 0, 1, 1, ST_OK, 0, 0);
        add_row(CMD_ENQ, 1, 32'hA5A5_A5A5, 1, 1, ST_OK, 0, 0);
        add_row(CMD_ENQ, 2, 32'h5A5A_5A5A, 1, 1, ST_OK, 0, 0);
        add_row(CMD_DEQ, 3, '1, 1, 1, ST_OK, 0, 0);
        add_row(CMD_DEQ, 0, 0, 1, 1, ST_OK, 32'hA5A5_A5A5, 1);
        add_row(CMD_DEQ, 0, 0, 1, 1, ST_OK, 32'h5A5A_5A5A, 2);
        add_row(CMD_DEQ, 0, 0, 1, 1, ST_OK, '1, 3);
        add_row(CMD_DEQ, 0, 0, 1, 1, ST_EMPTY, 0, 0);
        // fill one level, overflow it, then drain across levels
        add_row(CMD_ENQ, 2, 32'h0000_0100, 16, 0, ST_OK, 0, 0);
        add_row(CMD_ENQ, 2, 32'hDEAD_BEEF, 1, 1, ST_FULL, 0, 0);
        add_row(CMD_ENQ, 1, 32'h8000_0001, 3, 0, ST_OK, 0, 0);
        add_row(CMD_ENQ, 2, 0, 1, 1, ST_FULL, 0, 0);
        add_row(CMD_DEQ, 0, 0, 20, 0, ST_OK, 0, 0);
        // more items after level 2's pointers wrapped past the end of its ring above
        add_row(CMD_ENQ, 2, 32'h7000_0000, 5, 0, ST_OK, 0, 0);
        add_row(CMD_ENQ, 0, 32'hFFFF_0000, 2, 0, ST_OK, 0, 0);
        add_row(CMD_DEQ, 1, 0, 8, 0, ST_OK, 0, 0);

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[r]) begin
            for (int k = 0; k < directed_rows[r].reps; k++) begin
                send_item(directed_rows[r].cmd, directed_rows[r].level,
                          directed_rows[r].data + WORD_W'(k),
                          directed_rows[r].typed, directed_rows[r].want, 0);
            end
        end

        // random traffic in bursts; each burst leans toward filling, draining or neither
        for (int p = 0; p < 4; p++) begin
            case (p)
                1: idle_pct = 83;
                3: idle_pct = 35;
                default: idle_pct = 0;
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                burst_len  = $urandom_range(8, 40);
                burst_idle = ($urandom_range(2) == 0) ? 0 : idle_pct;
                case ($urandom_range(2))
                    0: enq_bias = 85;
                    1: enq_bias = 50;
                    default: enq_bias = 15;
                endcase
                pin_level = (enq_bias == 85 && $urandom_range(1)) ?
                            $urandom_range(NUM_LEVELS - 1) : -1;
                for (int k = 0; k < burst_len; k++) begin
                    c = ($urandom_range(99) < enq_bias) ? CMD_ENQ : CMD_DEQ;
                    l = (pin_level >= 0) ? LVL_W'(pin_level) : LVL_W'($urandom);
                    case ($urandom_range(7))
                        0: d = '0;
                        1: d = '1;
                        default: d = $urandom;
                    endcase
                    send_item(c, l, d, 0, none, burst_idle);
                end
                sent += burst_len;
            end
        end
        start <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);

        $display("%0d items: %0d enqueued, %0d rejected full, %0d dequeued, %0d on empty",
                 n_items, n_enq_ok, n_full, n_deq_ok, n_empty);
        $display("%0d results checked, %0d mismatches", n_results, errors);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/smpf_pkg.sv
rtl/smpf_store.sv
rtl/smpf_ptrs.sv
rtl/strict_priority_multi_fifo_top.sv
rtl/smpf_chk.sv
bench/tb.sv
